>>> rtl/mvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types and constants for the streaming matrix-vector multiply core.
// ----------------------------------------------------------------------------
package mvm_pkg;

    localparam int VALUE_W     = 24;  // Q8.16 entry width
    localparam int PROD_W      = 2 * VALUE_W;
    localparam int SUM_W       = 56;  // Q24.32 row sum width
    localparam int INDEX_W     = 6;
    localparam int COL_CNT_W   = 7;
    localparam int ROW_CNT_W   = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    localparam int MAX_COLUMNS_DEFAULT = 64;

    localparam logic [COL_CNT_W-1:0] COL_CNT_RESET = COL_CNT_W'(32);
    localparam logic [ROW_CNT_W-1:0] ROW_CNT_RESET = ROW_CNT_W'(32);

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 1'b1;

    // input transaction kinds
    localparam logic ACTION_LOAD   = 1'b0;
    localparam logic ACTION_MATRIX = 1'b1;

    typedef struct packed {
        logic                      action;
        logic [INDEX_W-1:0]        entry_index;
        logic signed [VALUE_W-1:0] entry_value;
    } in_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] row_sum;
        logic                    last_row;
    } out_t;

    // control that travels with a matrix entry down the MAC pipeline
    typedef struct packed {
        logic valid;
        logic end_row;
        logic last_row;
    } tag_t;

endpackage

>>> rtl/mvm_vec_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvm_vec_store
// Vector entry memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mvm_vec_store #(
    parameter int DEPTH  = mvm_pkg::MAX_COLUMNS_DEFAULT,
    parameter int ADDR_W = 6
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic                              wr_en,
    input  logic [ADDR_W-1:0]                 wr_addr,
    input  logic signed [mvm_pkg::VALUE_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]                 rd_addr,
    output logic signed [mvm_pkg::VALUE_W-1:0] rd_data
);

    logic signed [mvm_pkg::VALUE_W-1:0] mem [DEPTH];
    logic signed [mvm_pkg::VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (en && wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read and write never target the same edge with a dependency: a load
    // written at one edge is visible to a read at the next.
    always_ff @(posedge aclk) begin
        if (en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/mvm_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvm_mac
// Multiply-accumulate pipeline with the result output register.
// ----------------------------------------------------------------------------
module mvm_mac (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  mvm_pkg::tag_t                      tag_in,
    input  logic signed [mvm_pkg::VALUE_W-1:0] a_in,
    input  logic signed [mvm_pkg::VALUE_W-1:0] b_rd,
    output logic                               stall,
    output logic                               m_valid,
    input  logic                               m_ready,
    output mvm_pkg::out_t                      m_data
);

    localparam int PW = mvm_pkg::PROD_W;
    localparam int SW = mvm_pkg::SUM_W;

    mvm_pkg::tag_t                      tag1_reg, tag2_reg;
    logic signed [mvm_pkg::VALUE_W-1:0] a_reg;
    logic signed [PW-1:0]               prod_reg;
    logic signed [PW-1:0]               prod_next;
    logic signed [SW-1:0]               acc_reg;
    logic signed [SW-1:0]               sum_next;
    logic                               m_valid_reg;
    mvm_pkg::out_t                      m_data_reg;
    logic                               advance;

    // only a finished row blocked by a full output register holds the pipe
    assign stall   = tag2_reg.valid && tag2_reg.end_row && m_valid_reg && !m_ready;
    assign advance = !stall;

    assign prod_next = a_reg * b_rd;
    assign sum_next  = acc_reg + {{(SW - PW){prod_reg[PW-1]}}, prod_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end else if (advance) begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_reg    <= a_in;
            prod_reg <= prod_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (advance && tag2_reg.valid) begin
            acc_reg <= tag2_reg.end_row ? '0 : sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && tag2_reg.valid && tag2_reg.end_row) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && tag2_reg.valid && tag2_reg.end_row) begin
            m_data_reg.row_sum  <= sum_next;
            m_data_reg.last_row <= tag2_reg.last_row;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> rtl/matrix_vector_multiply_stream_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_vector_multiply_stream_core
// Streaming y = A*b in signed Q8.16, one row sum in Q24.32 per matrix row.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel (valid/ready) carries load and matrix transactions. A load
//   writes entry_value into the vector store at entry_index. Matrix entries
//   arrive in row-major order; each one is multiplied by the stored vector
//   entry at the current column and accumulated.
//   m_* channel (valid/ready) returns one row_sum per completed row, with
//   last_row set on the final row of the matrix.
//   cfg_* port writes column_count (index 0) and row_count (index 1); the user
//   must write them only while the core is idle, the core does not enforce it.
//   Throughput: one transaction per cycle while s_ready is high. After the last
//   entry of a row is accepted, the vector store read happens on the accepting
//   edge, then multiply, then accumulate into the output register, which sets m_valid.
//   Reset clears the column and row positions, the accumulator and the
//   output valid flag; the vector store holds nothing until loaded.
//   When the receiver stalls, the pipeline keeps accepting until a second
//   row result reaches the accumulate stage; s_ready then drops until the
//   waiting result is taken.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_stream_core #(
    parameter int MAX_COLUMNS = mvm_pkg::MAX_COLUMNS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  mvm_pkg::in_t                        s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output mvm_pkg::out_t                       m_data,
    input  logic                                cfg_wr_en,
    input  logic [mvm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mvm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int EW = (CW + 1 > mvm_pkg::COL_CNT_W) ? CW + 1 : mvm_pkg::COL_CNT_W;
    localparam int IW = (CW > mvm_pkg::INDEX_W) ? CW : mvm_pkg::INDEX_W;
    localparam int RW = mvm_pkg::ROW_CNT_W;

    logic [mvm_pkg::COL_CNT_W-1:0] column_count_reg;
    logic [RW-1:0]                 row_count_reg;
    logic [CW-1:0]                 col_pos_reg, col_pos_next;
    logic [RW-1:0]                 row_pos_reg, row_pos_next;

    logic          accept;
    logic          is_matrix;
    logic          stall;
    logic          load_we;
    logic [IW-1:0] idx_ext;
    logic [EW-1:0] cols_eff;
    logic [EW-1:0] col_cnt_ext;
    logic [RW-1:0] rows_eff;
    logic          end_row;
    logic          last_row;
    mvm_pkg::tag_t tag_in;
    logic signed [mvm_pkg::VALUE_W-1:0] b_rd;

    assign s_ready   = !stall;
    assign accept    = s_valid && s_ready;
    assign is_matrix = (s_data.action == mvm_pkg::ACTION_MATRIX);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= mvm_pkg::COL_CNT_RESET;
            row_count_reg    <= mvm_pkg::ROW_CNT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mvm_pkg::REG_COLUMN_COUNT:
                    column_count_reg <= cfg_wdata[mvm_pkg::COL_CNT_W-1:0];
                mvm_pkg::REG_ROW_COUNT:
                    row_count_reg <= cfg_wdata[RW-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, counts above the store depth clamp to it
    assign col_cnt_ext = EW'(column_count_reg);
    always_comb begin
        priority if (column_count_reg == '0) begin
            cols_eff = EW'(1);
        end else if (col_cnt_ext > EW'(MAX_COLUMNS)) begin
            cols_eff = EW'(MAX_COLUMNS);
        end else begin
            cols_eff = col_cnt_ext;
        end
    end

    assign rows_eff = (row_count_reg == '0) ? RW'(1) : row_count_reg;
    assign end_row  = (EW'(col_pos_reg) + EW'(1)) >= cols_eff;
    assign last_row = ({1'b0, row_pos_reg} + (RW + 1)'(1)) >= {1'b0, rows_eff};

    always_comb begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        if (accept && is_matrix) begin
            if (end_row) begin
                col_pos_next = '0;
                row_pos_next = last_row ? '0 : row_pos_reg + RW'(1);
            end else begin
                col_pos_next = col_pos_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end else begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
        end
    end

    // loads beyond the store depth are dropped
    assign idx_ext = IW'(s_data.entry_index);
    assign load_we = accept && !is_matrix && (int'(idx_ext) < MAX_COLUMNS);

    assign tag_in.valid    = accept && is_matrix;
    assign tag_in.end_row  = end_row;
    assign tag_in.last_row = last_row;

    mvm_vec_store #(
        .DEPTH  (MAX_COLUMNS),
        .ADDR_W (CW)
    ) u_store (
        .aclk    (aclk),
        .en      (s_ready),
        .wr_en   (load_we),
        .wr_addr (idx_ext[CW-1:0]),
        .wr_data (s_data.entry_value),
        .rd_addr (col_pos_reg),
        .rd_data (b_rd)
    );

    mvm_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tag_in  (tag_in),
        .a_in    (s_data.entry_value),
        .b_rd    (b_rd),
        .stall   (stall),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> rtl/mvm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvm_checker
// Port-level checks for the matrix-vector multiply core.
// ----------------------------------------------------------------------------
module mvm_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input mvm_pkg::in_t  s_data,
    input logic          m_valid,
    input logic          m_ready,
    input mvm_pkg::out_t m_data
);

    // a held result keeps its transaction unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // reset empties the output register
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input backpressure only comes from a stalled output
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");

    // an empty output only fills from an earlier accepted matrix transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid)
            |-> $past(s_valid && s_ready && (s_data.action == mvm_pkg::ACTION_MATRIX), 3))
        else $error("result without a matrix transaction");

endmodule

bind matrix_vector_multiply_stream_core mvm_checker u_mvm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
